// ----- src/skpc_pkg.sv -----
// Shared types and constants for the soft-knee peak compressor.
// Holds the gain curve contents, built at elaboration; no dependencies.
package skpc_pkg;

    localparam int GAIN_TABLE_SIZE = 256;
    localparam int FRAC_BITS = 24;
    localparam int ENTRIES_PER_UNIT = GAIN_TABLE_SIZE / 4;
    localparam int KNEE_INDEX = (3 * ENTRIES_PER_UNIT) / 4;
    localparam int IDX_SHIFT = 18;

    localparam int SAMPLE_W = 32;
    localparam int OUT_W = 26;
    localparam int COEF_W = 25;
    localparam int ENV_W = 31;
    localparam int GAIN_W = 25;
    localparam int ROM_ADDR_W = 9;
    localparam int INDEX_W = ENV_W - IDX_SHIFT;

    localparam logic [COEF_W-1:0] COEF_RESET = 25'd69770;
    localparam logic [ENV_W-1:0] ENV_MAX = {ENV_W{1'b1}};
    localparam logic [ROM_ADDR_W-1:0] ROM_LAST = ROM_ADDR_W'(GAIN_TABLE_SIZE);

    typedef logic [GAIN_TABLE_SIZE:0][GAIN_W-1:0] gain_rom_t;

    // tanh knee gain: unity up to the knee, then 2^24*(64+32t)/((1+t)*i)
    function automatic gain_rom_t build_gain_rom();
        gain_rom_t rom;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] c31;
        logic [63:0] t;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] dvd;
        logic [63:0] dvs;
        logic [63:0] quo;
        logic [63:0] rem;
        sum = 64'd1 << 60;
        term = 64'd1 << 60;
        for (int k = 1; k <= 16; k++) begin
            dvd = term;
            dvs = 64'(8 * k);
            quo = '0;
            rem = '0;
            for (int b = 63; b >= 0; b--) begin
                rem = {rem[62:0], dvd[b]};
                if (rem >= dvs) begin
                    rem = rem - dvs;
                    quo[b] = 1'b1;
                end
            end
            term = quo;
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        c31 = (sum + (64'd1 << 28)) >> 29;
        t = 64'd1 << 31;
        for (int i = 0; i <= GAIN_TABLE_SIZE; i++) begin
            if (i <= KNEE_INDEX) begin
                rom[i] = GAIN_W'(64'd1 << FRAC_BITS);
            end else begin
                t = (t * c31 + (64'd1 << 30)) >> 31;
                num = (64'(ENTRIES_PER_UNIT) << 31) + 64'(ENTRIES_PER_UNIT / 2) * t;
                den = ((64'd1 << 31) + t) * 64'(i);
                dvd = (num << FRAC_BITS) + (den >> 1);
                dvs = den;
                quo = '0;
                rem = '0;
                for (int b = 63; b >= 0; b--) begin
                    rem = {rem[62:0], dvd[b]};
                    if (rem >= dvs) begin
                        rem = rem - dvs;
                        quo[b] = 1'b1;
                    end
                end
                rom[i] = quo[GAIN_W-1:0];
            end
        end
        return rom;
    endfunction

    localparam gain_rom_t GAIN_ROM = build_gain_rom();

endpackage

// ----- src/soft_knee_peak_compressor_core.sv -----
// Soft-knee peak compressor: peak envelope, gain curve ROM lookup with
// linear interpolation, sample scaling and clamp. Depends on skpc_pkg.
//
//  channel   dir  handshake           payload
//  s_        in   s_tvalid/s_tready   s_tdata[31:0]  sample_in
//  m_        out  m_tvalid/m_tready   m_tdata[31:0]  sample_out in [25:0]
//  cfg_      in   cfg_we              cfg_wdata[24:0] release_coef
//
// One item at a time; steps: accept, release multiply, envelope update with
// ROM read, interpolation multiply, gain multiply, clamp into output register.
// The gain ROM has a registered read of two neighboring entries.
// Reset clears the envelope and loads the release coefficient default.
// A result that still waits on m_tready holds the next item in its last step.
module soft_knee_peak_compressor_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] sample_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [25:0] sample_out, [31:26] zero
    input  logic        cfg_we,
    input  logic [24:0] cfg_wdata
);
    import skpc_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RELEASE = 3'd1;
    localparam logic [2:0] ST_UPDATE  = 3'd2;
    localparam logic [2:0] ST_INTERP  = 3'd3;
    localparam logic [2:0] ST_SCALE   = 3'd4;
    localparam logic [2:0] ST_EMIT    = 3'd5;

    localparam int REL_P_W = COEF_W + ENV_W;
    localparam int DELTA_W = GAIN_W + 1;
    localparam int INTERP_P_W = DELTA_W + IDX_SHIFT + 1;
    localparam int GSUM_W = GAIN_W + 2;
    localparam int SCALE_P_W = SAMPLE_W + OUT_W;
    localparam int Y_W = SCALE_P_W - FRAC_BITS;

    localparam logic signed [Y_W-1:0] ONE_Y = Y_W'(64'd1 << FRAC_BITS);
    localparam logic signed [Y_W-1:0] NEG_ONE_Y = -ONE_Y;

    logic [2:0]                    state_reg, state_next;
    logic [COEF_W-1:0]             coef_reg;
    logic [ENV_W-1:0]              env_reg, env_next;
    logic signed [SAMPLE_W-1:0]    sample_reg;
    logic [SAMPLE_W-1:0]           mag_reg;
    logic                          rise_reg;
    logic [REL_P_W-1:0]            rel_prod_reg;
    logic [IDX_SHIFT-1:0]          frac_reg;
    logic [GAIN_W-1:0]             rom_lo_reg;
    logic [GAIN_W-1:0]             rom_hi_reg;
    logic signed [INTERP_P_W-1:0]  interp_prod_reg;
    logic [GAIN_W-1:0]             gain_base_reg;
    logic signed [SCALE_P_W-1:0]   scale_prod_reg;
    logic                          m_tvalid_reg;
    logic [31:0]                   m_tdata_reg;

    logic [SAMPLE_W-1:0]           s_mag;
    logic                          rise;
    logic [ENV_W-1:0]              diff;
    logic [REL_P_W:0]              rel_round;
    logic [SAMPLE_W:0]             dec;
    logic [INDEX_W-1:0]            index;
    logic                          beyond;
    logic [ROM_ADDR_W-1:0]         addr_lo;
    logic [ROM_ADDR_W-1:0]         addr_hi;
    logic signed [DELTA_W-1:0]     delta;
    logic signed [GSUM_W-1:0]      gain_sum;
    logic signed [Y_W-1:0]         y;
    logic signed [OUT_W-1:0]       y_clamped;
    logic                          out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_mag = s_tdata[SAMPLE_W-1] ? (SAMPLE_W'(0) - s_tdata) : s_tdata;
    assign rise  = mag_reg > {1'b0, env_reg};
    assign diff  = env_reg - mag_reg[ENV_W-1:0];

    assign rel_round = {1'b0, rel_prod_reg} + ((REL_P_W+1)'(1) << FRAC_BITS)
                       - (REL_P_W+1)'(1);
    assign dec = (SAMPLE_W+1)'(rel_round >> FRAC_BITS);

    always_comb begin
        env_next = env_reg;
        if (rise_reg) begin
            env_next = mag_reg[SAMPLE_W-1] ? ENV_MAX : mag_reg[ENV_W-1:0];
        end else if (dec > {2'b00, env_reg}) begin
            env_next = '0;
        end else begin
            env_next = env_reg - dec[ENV_W-1:0];
        end
    end

    assign index  = env_next[ENV_W-1:IDX_SHIFT];
    assign beyond = |index[INDEX_W-1:ROM_ADDR_W-1];
    assign addr_lo = beyond ? ROM_LAST : {1'b0, index[ROM_ADDR_W-2:0]};
    assign addr_hi = beyond ? ROM_LAST : ({1'b0, index[ROM_ADDR_W-2:0]} + ROM_ADDR_W'(1));

    assign delta = $signed({1'b0, rom_hi_reg}) - $signed({1'b0, rom_lo_reg});
    assign gain_sum = $signed({2'b00, gain_base_reg})
                      + GSUM_W'(interp_prod_reg >>> IDX_SHIFT);

    assign y = Y_W'(scale_prod_reg >>> FRAC_BITS);

    always_comb begin
        if (y > ONE_Y) begin
            y_clamped = ONE_Y[OUT_W-1:0];
        end else if (y < NEG_ONE_Y) begin
            y_clamped = NEG_ONE_Y[OUT_W-1:0];
        end else begin
            y_clamped = y[OUT_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RELEASE;
                end
            end
            ST_RELEASE: state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_INTERP;
            ST_INTERP:  state_next = ST_SCALE;
            ST_SCALE:   state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            coef_reg     <= COEF_RESET;
            env_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                coef_reg <= cfg_wdata;
            end
            if (state_reg == ST_UPDATE) begin
                env_reg <= env_next;
            end
            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= $signed(s_tdata);
            mag_reg    <= s_mag;
        end
        if (state_reg == ST_RELEASE) begin
            rise_reg     <= rise;
            rel_prod_reg <= REL_P_W'(coef_reg) * REL_P_W'(diff);
        end
        if (state_reg == ST_UPDATE) begin
            frac_reg   <= env_next[IDX_SHIFT-1:0];
            rom_lo_reg <= GAIN_ROM[addr_lo];
            rom_hi_reg <= GAIN_ROM[addr_hi];
        end
        if (state_reg == ST_INTERP) begin
            gain_base_reg   <= rom_lo_reg;
            interp_prod_reg <= INTERP_P_W'(delta) * $signed({1'b0, frac_reg});
        end
        if (state_reg == ST_SCALE) begin
            scale_prod_reg <= SCALE_P_W'(sample_reg) * SCALE_P_W'(gain_sum[OUT_W-1:0]);
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_tdata_reg <= {{(32-OUT_W){1'b0}}, y_clamped};
        end
    end

endmodule
